@@ hw/rtl/afr_pkg.sv @@
package afr_pkg;

    // Input beat kinds (tuser on the slave side)
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // Result event codes (tuser on the master side)
    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_END     = 2'd1;
    localparam logic [1:0] EV_TIMEOUT = 2'd2;

    // Frame constants
    localparam logic [7:0] DELIM_BYTE  = 8'h7E;
    localparam logic [7:0] GOOD_SUM    = 8'hFF;
    localparam logic [7:0] LIMIT_RESET = 8'd30;

    // One input item as held in the input register
    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_item;

    // One result item
    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_good;
        logic [7:0] frame_length;
    } t_result;

endpackage

@@ hw/rtl/afr_in_stage.sv @@
module afr_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  afr_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output afr_pkg::t_item o_item
);

    logic           r_valid;
    afr_pkg::t_item r_item;

    // Register is free when empty or when its beat moves on this cycle
    assign o_s_tready = !r_valid || i_advance;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hw/rtl/afr_core.sv @@
module afr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  logic             i_fire,
    input  afr_pkg::t_item   i_item,
    output logic             o_res_valid,
    output afr_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HUNT    = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_hunt_limit;
    logic [7:0] r_hunt_count, n_hunt_count;
    logic [7:0] r_payload_length, n_payload_length;
    logic [7:0] r_byte_position, n_byte_position;
    logic [7:0] r_running_sum, n_running_sum;
    logic [7:0] sum_plus;
    logic [7:0] pos_plus;

    assign sum_plus = r_running_sum + i_item.rx_byte;
    assign pos_plus = r_byte_position + 8'd1;

    // Next state and result for the beat in the input register
    always_comb begin
        n_phase          = r_phase;
        n_hunt_count     = r_hunt_count;
        n_payload_length = r_payload_length;
        n_byte_position  = r_byte_position;
        n_running_sum    = r_running_sum;
        o_res_valid      = 1'b0;
        o_res            = '0;

        if (i_fire) begin
            if (i_item.kind == afr_pkg::KIND_START) begin
                // start is ignored during an attempt
                if (r_phase == PH_IDLE) begin
                    n_hunt_count    = '0;
                    n_running_sum   = '0;
                    n_byte_position = '0;
                    n_phase         = PH_HUNT;
                end
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (r_hunt_count >= r_hunt_limit) begin
                            // timeout, or delimiter refused at the limit
                            n_phase         = PH_IDLE;
                            o_res_valid     = 1'b1;
                            o_res.event_res = afr_pkg::EV_TIMEOUT;
                        end else if (i_item.rx_byte == afr_pkg::DELIM_BYTE) begin
                            n_phase = PH_LEN_HI;
                        end else begin
                            n_hunt_count = r_hunt_count + 8'd1;
                        end
                    end
                    PH_LEN_HI: begin
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_payload_length = i_item.rx_byte;
                        n_byte_position  = '0;
                        n_phase = (i_item.rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        o_res_valid         = 1'b1;
                        o_res.event_res     = afr_pkg::EV_PAYLOAD;
                        o_res.payload_byte  = i_item.rx_byte;
                        o_res.payload_index = r_byte_position;
                        o_res.frame_length  = r_payload_length;
                        n_running_sum       = sum_plus;
                        n_byte_position     = pos_plus;
                        if (pos_plus >= r_payload_length) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        n_running_sum      = sum_plus;
                        n_phase            = PH_IDLE;
                        o_res_valid        = 1'b1;
                        o_res.event_res    = afr_pkg::EV_END;
                        o_res.frame_good   = (sum_plus == afr_pkg::GOOD_SUM);
                        o_res.frame_length = r_payload_length;
                    end
                    default: begin
                        // idle: stray bytes are dropped
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_hunt_limit     <= afr_pkg::LIMIT_RESET;
            r_hunt_count     <= '0;
            r_payload_length <= '0;
            r_byte_position  <= '0;
            r_running_sum    <= '0;
        end else begin
            r_phase          <= n_phase;
            r_hunt_count     <= n_hunt_count;
            r_payload_length <= n_payload_length;
            r_byte_position  <= n_byte_position;
            r_running_sum    <= n_running_sum;
            if (i_cfg_wr_en) begin
                r_hunt_limit <= i_cfg_wr_data;
            end
        end
    end

endmodule

@@ hw/rtl/afr_out_reg.sv @@
module afr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  afr_pkg::t_result i_res,
    output logic             o_advance,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output afr_pkg::t_result o_res
);

    logic             r_valid;
    afr_pkg::t_result r_res;

    // Loadable when empty or when the held beat is taken now
    assign o_advance = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_res      = r_res;

endmodule

@@ hw/rtl/api_frame_receiver_unit.sv @@
// An accepted input beat waits in the input register; its result goes to the result
// register. The two set the pace: one input beat per cycle unless the master stalls.
// A beat that causes no result only updates the frame state.
// Reset (i_rst_n low, synchronous): both registers empty, phase idle,
// counters and checksum cleared, hunt limit back to 30.
module api_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: hunt limit
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] rx_byte
    input  logic        i_s_tuser,  // [0] kind
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [7:0] payload_byte, [15:8] payload_index,
                                    // [16] frame_good, [24:17] frame_length, rest 0
    output logic [1:0]  o_m_tuser   // [1:0] event_res
);

    afr_pkg::t_item   s_item;
    afr_pkg::t_item   in_item;
    afr_pkg::t_result core_res;
    afr_pkg::t_result out_res;
    logic             in_valid;
    logic             advance;
    logic             fire;
    logic             res_valid;

    assign s_item.kind    = i_s_tuser;
    assign s_item.rx_byte = i_s_tdata;

    afr_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_item     (s_item),
        .i_advance  (advance),
        .o_valid    (in_valid),
        .o_item     (in_item)
    );

    // Held beat is processed when the result register can load
    assign fire = in_valid && advance;

    afr_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_item        (in_item),
        .o_res_valid   (res_valid),
        .o_res         (core_res)
    );

    afr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (core_res),
        .o_advance   (advance),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_res       (out_res)
    );

    // Pack result fields onto the bus
    assign o_m_tuser = out_res.event_res;
    assign o_m_tdata = {7'd0, out_res.frame_length, out_res.frame_good,
                        out_res.payload_index, out_res.payload_byte};

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 200;
    localparam int RANDOM_ITEMS  = 300;

    // Frame receiver phases, as tracked by the predictor
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HUNT    = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] rx_byte
    logic        i_s_tuser;   // [0] kind
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // [7:0] byte, [15:8] index, [16] good, [24:17] length
    logic [1:0]  o_m_tuser;   // [1:0] event_res

    // Predicted frame state
    logic [7:0]  lim_m      = afr_pkg::LIMIT_RESET;
    t_phase      phase_m    = PH_IDLE;
    logic [7:0]  hunt_cnt_m = 8'd0;
    logic [7:0]  len_m      = 8'd0;
    logic [7:0]  pos_m      = 8'd0;
    logic [7:0]  sum_m      = 8'd0;

    afr_pkg::t_result pending_events[$];
    int unsigned mismatches     = 0;
    int unsigned items_sent     = 0;
    bit          tx_gaps_on     = 1'b1;
    bit          rx_stalls_on   = 1'b1;
    int unsigned rx_hold_cycles = 0;

    api_frame_receiver_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Frame receive predictor: one input beat in, at most one event out
    task automatic frame_rx_step(input logic kind, input logic [7:0] b,
                                 output bit has_ev, output afr_pkg::t_result ev);
        has_ev = 1'b0;
        ev     = '0;
        if (kind == afr_pkg::KIND_START) begin
            if (phase_m == PH_IDLE) begin
                hunt_cnt_m = 8'd0;
                sum_m      = 8'd0;
                pos_m      = 8'd0;
                phase_m    = PH_HUNT;
            end
        end else begin
            case (phase_m)
                PH_HUNT: begin
                    if (b == afr_pkg::DELIM_BYTE && hunt_cnt_m < lim_m) begin
                        phase_m = PH_LEN_HI;
                    end else if (b == afr_pkg::DELIM_BYTE || hunt_cnt_m >= lim_m) begin
                        // delimiter refused or too many stray bytes
                        phase_m      = PH_IDLE;
                        has_ev       = 1'b1;
                        ev.event_res = afr_pkg::EV_TIMEOUT;
                    end else begin
                        hunt_cnt_m = hunt_cnt_m + 8'd1;
                    end
                end
                PH_LEN_HI: phase_m = PH_LEN_LO;
                PH_LEN_LO: begin
                    len_m   = b;
                    pos_m   = 8'd0;
                    phase_m = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    has_ev           = 1'b1;
                    ev.event_res     = afr_pkg::EV_PAYLOAD;
                    ev.payload_byte  = b;
                    ev.payload_index = pos_m;
                    ev.frame_length  = len_m;
                    sum_m            = sum_m + b;
                    pos_m            = pos_m + 8'd1;
                    if (pos_m >= len_m) begin
                        phase_m = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    sum_m           = sum_m + b;
                    phase_m         = PH_IDLE;
                    has_ev          = 1'b1;
                    ev.event_res    = afr_pkg::EV_END;
                    ev.frame_good   = (sum_m == afr_pkg::GOOD_SUM);
                    ev.frame_length = len_m;
                end
                default: phase_m = PH_IDLE;
            endcase
        end
    endtask

    // Drive one beat on the slave side and record what it should produce
    task automatic send_item(input logic kind, input logic [7:0] b);
        int unsigned      gap;
        bit               has_ev;
        afr_pkg::t_result ev;
        gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        frame_rx_step(kind, b, has_ev, ev);
        if (has_ev) begin
            pending_events.push_back(ev);
        end
        items_sent++;
    endtask

    function automatic logic [7:0] rand_non_delim();
        logic [7:0] v;
        v = 8'($urandom_range(0, 254));
        if (v >= afr_pkg::DELIM_BYTE) begin
            v = v + 8'd1;
        end
        return v;
    endfunction

    // Pipeline empty: all events out and the last beat settled
    task automatic wait_drained();
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        i_s_tvalid <= 1'b0;
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        lim_m = v;
    endtask

    // Start, stray bytes, delimiter, length, payload, checksum
    task automatic send_frame(input int unsigned noise, input int unsigned len,
                              input bit good);
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned k;
        sum = 8'd0;
        send_item(afr_pkg::KIND_START, 8'($urandom));
        for (k = 0; k < noise; k++) send_item(afr_pkg::KIND_BYTE, rand_non_delim());
        send_item(afr_pkg::KIND_BYTE, afr_pkg::DELIM_BYTE);
        send_item(afr_pkg::KIND_BYTE, 8'($urandom));
        send_item(afr_pkg::KIND_BYTE, 8'(len));
        for (k = 0; k < len; k++) begin
            b   = 8'($urandom);
            sum = sum + b;
            send_item(afr_pkg::KIND_BYTE, b);
        end
        send_item(afr_pkg::KIND_BYTE, good ? afr_pkg::GOOD_SUM - sum : 8'($urandom));
    endtask

    // Feed bytes until the receiver is back in idle
    task automatic drain_to_idle();
        while (phase_m != PH_IDLE) begin
            send_item(afr_pkg::KIND_BYTE,
                      (phase_m == PH_HUNT) ? rand_non_delim() : 8'($urandom));
        end
    endtask

    task automatic test_directed_frames();
        // bytes while idle are dropped
        send_item(afr_pkg::KIND_BYTE, afr_pkg::DELIM_BYTE);
        send_item(afr_pkg::KIND_BYTE, 8'h00);
        // second start ignored, stray bytes, extreme payload values, good sum
        send_item(afr_pkg::KIND_START, 8'hFF);
        send_item(afr_pkg::KIND_START, 8'h00);
        send_item(afr_pkg::KIND_BYTE, 8'h00);
        send_item(afr_pkg::KIND_BYTE, 8'hFF);
        send_item(afr_pkg::KIND_BYTE, afr_pkg::DELIM_BYTE);
        send_item(afr_pkg::KIND_BYTE, 8'hFF);
        send_item(afr_pkg::KIND_BYTE, 8'h03);
        send_item(afr_pkg::KIND_BYTE, 8'h00);
        send_item(afr_pkg::KIND_BYTE, 8'hFF);
        send_item(afr_pkg::KIND_BYTE, 8'h80);
        send_item(afr_pkg::KIND_BYTE, 8'h80);
        // zero length, good then bad checksum
        send_item(afr_pkg::KIND_START, 8'h00);
        send_item(afr_pkg::KIND_BYTE, afr_pkg::DELIM_BYTE);
        send_item(afr_pkg::KIND_BYTE, 8'h00);
        send_item(afr_pkg::KIND_BYTE, 8'h00);
        send_item(afr_pkg::KIND_BYTE, afr_pkg::GOOD_SUM);
        send_item(afr_pkg::KIND_START, 8'h00);
        send_item(afr_pkg::KIND_BYTE, afr_pkg::DELIM_BYTE);
        send_item(afr_pkg::KIND_BYTE, 8'h12);
        send_item(afr_pkg::KIND_BYTE, 8'h00);
        send_item(afr_pkg::KIND_BYTE, 8'h00);
    endtask

    task automatic test_hunt_limits();
        int unsigned k;
        // zero limit: delimiter refused, stray byte times out
        write_limit(8'd0);
        send_item(afr_pkg::KIND_START, 8'h00);
        send_item(afr_pkg::KIND_BYTE, afr_pkg::DELIM_BYTE);
        send_item(afr_pkg::KIND_START, 8'h00);
        send_item(afr_pkg::KIND_BYTE, 8'h00);
        // limit of two: timeout, refusal, then acceptance
        write_limit(8'd2);
        send_item(afr_pkg::KIND_START, 8'h00);
        send_item(afr_pkg::KIND_BYTE, 8'h01);
        send_item(afr_pkg::KIND_BYTE, 8'h02);
        send_item(afr_pkg::KIND_BYTE, 8'h03);
        send_item(afr_pkg::KIND_START, 8'h00);
        send_item(afr_pkg::KIND_BYTE, 8'h01);
        send_item(afr_pkg::KIND_BYTE, 8'h02);
        send_item(afr_pkg::KIND_BYTE, afr_pkg::DELIM_BYTE);
        send_frame(1, 0, 1'b1);
        // limit lowered in the middle of a hunt
        write_limit(8'd10);
        send_item(afr_pkg::KIND_START, 8'h00);
        for (k = 0; k < 5; k++) send_item(afr_pkg::KIND_BYTE, rand_non_delim());
        write_limit(8'd3);
        send_item(afr_pkg::KIND_BYTE, rand_non_delim());
        // full limit: count runs up to 255
        write_limit(8'd255);
        send_item(afr_pkg::KIND_START, 8'h00);
        for (k = 0; k < 255; k++) send_item(afr_pkg::KIND_BYTE, rand_non_delim());
        send_item(afr_pkg::KIND_BYTE, afr_pkg::DELIM_BYTE);
        send_item(afr_pkg::KIND_START, 8'h00);
        for (k = 0; k < 256; k++) send_item(afr_pkg::KIND_BYTE, rand_non_delim());
        // longest payload, index reaches 254
        send_frame(4, 255, 1'b1);
        write_limit(afr_pkg::LIMIT_RESET);
    endtask

    task automatic test_backpressure();
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = LONG_HOLD;
        send_frame(0, 100, 1'b1);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        int unsigned sel;
        int unsigned k;
        int unsigned len;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            // occasional limit change, extremes included
            if ($urandom_range(0, 9) == 0) begin
                sel = $urandom_range(0, 7);
                case (sel)
                    0:       write_limit(8'd0);
                    1:       write_limit(8'd255);
                    2:       write_limit(8'($urandom_range(1, 3)));
                    default: write_limit(8'($urandom_range(4, 60)));
                endcase
            end
            // stretches with and without idling
            if ($urandom_range(0, 7) == 0) begin
                tx_gaps_on   = 1'($urandom_range(0, 1));
                rx_stalls_on = 1'($urandom_range(0, 1));
            end
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                drain_to_idle();
                len = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 8);
                k = (lim_m < 4) ? 32'(lim_m) : 4;
                send_frame($urandom_range(0, k), len, $urandom_range(0, 3) != 0);
            end else if (sel == 7) begin
                // raw noise, starts and bytes alike
                for (k = $urandom_range(1, 6); k > 0; k--) begin
                    send_item(1'($urandom), 8'($urandom));
                end
            end else if (sel == 8) begin
                // frame cut short, the rest comes from whatever follows
                drain_to_idle();
                len = $urandom_range(3, 8);
                send_item(afr_pkg::KIND_START, 8'($urandom));
                send_item(afr_pkg::KIND_BYTE, afr_pkg::DELIM_BYTE);
                send_item(afr_pkg::KIND_BYTE, 8'($urandom));
                send_item(afr_pkg::KIND_BYTE, 8'(len));
                for (k = $urandom_range(0, len - 1); k > 0; k--) begin
                    send_item(afr_pkg::KIND_BYTE, 8'($urandom));
                end
                send_item(afr_pkg::KIND_START, 8'($urandom));
            end else begin
                // hunt running out of stray bytes
                drain_to_idle();
                send_item(afr_pkg::KIND_START, 8'($urandom));
                if (lim_m <= 8'd40) begin
                    for (k = 0; k <= 32'(lim_m); k++) begin
                        send_item(afr_pkg::KIND_BYTE, rand_non_delim());
                    end
                end
            end
        end
    endtask

    // Result sink with random stalls and one long hold
    initial begin : result_sink
        int unsigned stall;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles != 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rx_stalls_on ? $urandom_range(0, 3) : 0;
            end
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    task automatic note_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
        end
    endtask

    // Compare each result beat with the oldest predicted event
    always @(posedge i_clk) begin : event_check
        afr_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_events.size() == 0) begin
                note_mismatch("unexpected result beat, event", 0, 32'(o_m_tuser));
            end else begin
                want = pending_events.pop_front();
                if (o_m_tuser != want.event_res)
                    note_mismatch("event_res", 32'(want.event_res), 32'(o_m_tuser));
                if (o_m_tdata[7:0] != want.payload_byte)
                    note_mismatch("payload_byte", 32'(want.payload_byte),
                                  32'(o_m_tdata[7:0]));
                if (o_m_tdata[15:8] != want.payload_index)
                    note_mismatch("payload_index", 32'(want.payload_index),
                                  32'(o_m_tdata[15:8]));
                if (o_m_tdata[16] != want.frame_good)
                    note_mismatch("frame_good", 32'(want.frame_good), 32'(o_m_tdata[16]));
                if (o_m_tdata[24:17] != want.frame_length)
                    note_mismatch("frame_length", 32'(want.frame_length),
                                  32'(o_m_tdata[24:17]));
                if (o_m_tdata[31:25] != 7'd0)
                    note_mismatch("tdata padding", 0, 32'(o_m_tdata[31:25]));
            end
        end
    end

    // Test sequence
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 8'd0;
        i_s_tvalid    <= 1'b0;
        i_s_tdata     <= 8'd0;
        i_s_tuser     <= afr_pkg::KIND_START;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_hunt_limits();
        test_backpressure();
        test_random_traffic();

        i_s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
